// ----- design/wam_pkg.sv -----
// Shared types and constants for the weekly alarm matcher.
// No dependencies; imported by the channel interfaces and the top level.
package wam_pkg;

    localparam int NUM_ALARMS = 8;
    localparam int MASK_W     = 8;

    // Command codes carried in the cmd field
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_CLOSE = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam int REPEAT_DAILY_BIT = 7;

    typedef logic [MASK_W-1:0] mask_t;

    typedef struct packed {
        logic       on;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [7:0] rpt;
    } entry_t;

endpackage

// ----- design/wam_req_if.sv -----
// Command channel of the weekly alarm matcher: valid/ready plus command payload.
// Depends on wam_pkg (loaded first).
interface wam_req_if
    import wam_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [2:0] now_weekday;
    logic [2:0] entry_index;
    logic       entry_enable;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [7:0] entry_repeat;

    modport source (
        output valid, cmd, now_second, now_minute, now_hour, now_weekday,
               entry_index, entry_enable, entry_hour, entry_minute, entry_repeat,
        input  ready
    );
    modport sink (
        input  valid, cmd, now_second, now_minute, now_hour, now_weekday,
               entry_index, entry_enable, entry_hour, entry_minute, entry_repeat,
        output ready
    );
endinterface

// ----- design/wam_rsp_if.sv -----
// Result channel of the weekly alarm matcher: valid/ready plus status masks.
// Depends on wam_pkg (loaded first).
interface wam_rsp_if
    import wam_pkg::*;
();
    logic  valid;
    logic  ready;
    mask_t ringing_mask;
    logic  ring_start;
    mask_t enable_mask;

    modport source (
        output valid, ringing_mask, ring_start, enable_mask,
        input  ready
    );
    modport sink (
        input  valid, ringing_mask, ring_start, enable_mask,
        output ready
    );
endinterface

// ----- design/weekly_alarm_matcher.sv -----
// Weekly alarm matcher top level: alarm table, ringing mask and result register.
// Depends on wam_pkg, wam_req_if and wam_rsp_if.
//
// Usage:
//   req carries one command per beat: a time tick (match every entry against
//   the time of day), a close (stop ringing, retire one-shot entries that
//   rang) or a write of one alarm entry. rsp returns exactly one beat per
//   command with the ringing mask, the enable mask and a ring_start pulse.
//   cfg_we/cfg_wdata write the master enable switch; write it only while
//   no command is outstanding.
// The result beat is registered and valid in the cycle after the command beat.
// Throughput: one command per cycle unless rsp stalls. The table and ringing mask
// update at the accepting edge, so back-to-back commands see each other's effect.
// Stall: the single result register holds its beat while rsp.ready is low;
// req.ready follows, so a new command is taken in the cycle the result
// leaves (or whenever the register is empty).
// Reset: all entries disabled and zeroed, nothing ringing, master switch
// off, result register empty.
module weekly_alarm_matcher
    import wam_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    wam_req_if.sink   req,
    wam_rsp_if.source rsp
);

    entry_t alarm_reg  [NUM_ALARMS];
    entry_t alarm_next [NUM_ALARMS];
    mask_t  ringing_reg, ringing_next;
    logic   master_en_reg;

    logic   out_valid_reg;
    mask_t  out_ringing_reg;
    logic   out_start_reg;
    mask_t  out_enable_reg;

    mask_t  match_vec;
    mask_t  enable_vec;
    mask_t  enable_next;
    logic   start_next;
    logic   accept;
    logic [2:0] wd_m1;

    // Result register frees up when empty or being drained this cycle
    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    // weekday 1 selects repeat bit 0
    assign wd_m1 = req.now_weekday - 3'd1;

    // Per-entry comparators
    always_comb
    begin
        match_vec  = '0;
        enable_vec = '0;
        for (int k = 0; k < NUM_ALARMS; k++)
        begin
            enable_vec[k] = alarm_reg[k].on;
            match_vec[k]  = alarm_reg[k].on
                         && (req.now_second == 6'd0)
                         && (req.now_minute == alarm_reg[k].minute)
                         && (req.now_hour == alarm_reg[k].hour)
                         && ((alarm_reg[k].rpt == 8'd0)
                             || alarm_reg[k].rpt[REPEAT_DAILY_BIT]
                             || ((req.now_weekday != 3'd0) && alarm_reg[k].rpt[wd_m1]));
        end
    end

    // Next state for the command in flight
    always_comb
    begin
        alarm_next   = alarm_reg;
        ringing_next = ringing_reg;
        start_next   = 1'b0;
        case (req.cmd)
            CMD_TICK:
            begin
                // fires only with the switch on and nothing already ringing
                if (master_en_reg && (ringing_reg == '0))
                begin
                    ringing_next = match_vec;
                    start_next   = |match_vec;
                end
            end
            CMD_CLOSE:
            begin
                for (int k = 0; k < NUM_ALARMS; k++)
                begin
                    if (ringing_reg[k] && (alarm_reg[k].rpt == 8'd0))
                    begin
                        alarm_next[k].on = 1'b0;
                    end
                end
                ringing_next = '0;
            end
            CMD_WRITE:
            begin
                // ringing bit of a rewritten entry is kept
                if (int'(req.entry_index) < NUM_ALARMS)
                begin
                    alarm_next[req.entry_index[$clog2(NUM_ALARMS > 1 ? NUM_ALARMS : 2)-1:0]] =
                        '{on:     req.entry_enable,
                          hour:   req.entry_hour,
                          minute: req.entry_minute,
                          rpt:    req.entry_repeat};
                end
            end
            default:
            begin
                // unused code: report current state only
            end
        endcase

        enable_next = '0;
        for (int k = 0; k < NUM_ALARMS; k++)
        begin
            enable_next[k] = alarm_next[k].on;
        end
    end

    // Alarm table, ringing mask and master switch
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_ALARMS; k++)
            begin
                alarm_reg[k] <= '0;
            end
            ringing_reg   <= '0;
            master_en_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                alarm_reg   <= alarm_next;
                ringing_reg <= ringing_next;
            end
            if (cfg_we)
            begin
                master_en_reg <= cfg_wdata;
            end
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_ringing_reg <= ringing_next;
            out_start_reg   <= start_next;
            out_enable_reg  <= enable_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.ringing_mask = out_ringing_reg;
    assign rsp.ring_start   = out_start_reg;
    assign rsp.enable_mask  = out_enable_reg;

    // A waiting result always mirrors the live state: state moves only
    // when the result register is reloaded.
    a_result_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.ringing_mask == ringing_reg) && (rsp.enable_mask == enable_vec))
        else $error("result beat out of step with alarm state");

    a_start_needs_ringing: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.ring_start |-> (rsp.ringing_mask != '0))
        else $error("ring_start without any ringing entry");

    a_start_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.cmd != CMD_TICK) |=> !rsp.ring_start)
        else $error("ring_start on a non-tick command");

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.cmd == CMD_CLOSE) |=> (ringing_reg == '0))
        else $error("close left entries ringing");

    a_ringing_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ringing_reg != '0) && !(accept && (req.cmd == CMD_CLOSE))
        |=> (ringing_reg == $past(ringing_reg)))
        else $error("ringing mask changed without a close");

endmodule
